>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the line breaker core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that cond at one edge implies res at the next
`define ASSERT_NEXT(label, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error(msg);

`endif

>>> design/glb_pkg.sv
// ----------------------------------------------------------------------------
// Line breaker package
// Sizes, stored item and line bound types, and bound update helpers.
// ----------------------------------------------------------------------------
package glb_pkg;

  localparam int MAX_LINE_ITEMS = 64;
  localparam int AW = (MAX_LINE_ITEMS > 1) ? $clog2(MAX_LINE_ITEMS) : 1;
  localparam int CW = $clog2(MAX_LINE_ITEMS + 1);

  typedef struct packed {
    logic [19:0]        w;
    logic [19:0]        asc;
    logic signed [20:0] desc;
    logic               bb;
    logic               ba;
  } entry_t;

  typedef struct packed {
    logic [25:0]        width;
    logic [20:0]        height;
    logic [19:0]        ascent;
    logic signed [20:0] descent;
  } bounds_t;

  function automatic bounds_t add_bounds(bounds_t b, logic [19:0] w, logic [19:0] asc,
                                         logic signed [20:0] desc);
    bounds_t            r;
    logic [26:0]        sw;
    logic signed [21:0] h;
    logic signed [21:0] h2;
    r  = b;
    sw = {1'b0, b.width} + {7'd0, w};
    r.width = sw[26] ? 26'h3FFFFFF : sw[25:0];
    h = $signed({2'b00, asc}) + 22'(desc);
    if (h > $signed({1'b0, r.height})) r.height = h[20:0];
    if (asc > r.ascent) r.ascent = asc;
    if (desc > r.descent) r.descent = desc;
    h2 = $signed({2'b00, r.ascent}) + 22'(r.descent);
    if (h2 > $signed({1'b0, r.height})) r.height = h2[20:0];
    return r;
  endfunction

  function automatic logic [AW-1:0] slot_index(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(off);
    if (s >= (CW + 1)'(MAX_LINE_ITEMS)) s = s - (CW + 1)'(MAX_LINE_ITEMS);
    return s[AW-1:0];
  endfunction

endpackage

>>> design/glb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module glb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> design/greedy_line_breaker_core.sv
// ----------------------------------------------------------------------------
// Greedy line breaker core
// Fills lines greedily from a stream of inline items and reports each line.
// ----------------------------------------------------------------------------
// Input channel in_*: one beat per inline item, taken while in_stall is low.
// Result channel out_*: one beat per closed line; last_line marks the final
// line caused by an input beat. Config writes (cfg_we, cfg_index, cfg_wdata)
// set avail_width (index 0) and no_wrap (index 1); the user must write them
// only while the block is idle; the block itself does not enforce it.
// A plain append passes the decide, capacity check and append states before
// the next accept; a closed line adds the output load state. A wrap reads
// items back while scanning and every item on the line when bounds are
// rebuilt, all through the single read port of the item store RAM.
// Reset clears the open line, the sequence counter and the config registers;
// the item store needs no clearing. When the receiver stalls, the result beat
// holds and the sequencer waits before loading the next line; in_stall stays
// high until all results of the current item are handed to the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module greedy_line_breaker_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        in_item_width,
  input  logic [19:0]        in_item_ascent,
  input  logic signed [20:0] in_item_descent,
  input  logic               in_break_before,
  input  logic               in_break_after,
  input  logic               in_force_break,
  input  logic               in_end_of_items,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_first_item,
  output logic [6:0]         out_item_count,
  output logic [25:0]        out_line_width,
  output logic [20:0]        out_line_height,
  output logic [19:0]        out_line_baseline,
  output logic signed [20:0] out_line_descent,
  output logic               out_capacity_close,
  output logic               out_last_line,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [19:0]        cfg_wdata
);

  localparam int AW = glb_pkg::AW;
  localparam int CW = glb_pkg::CW;
  localparam int N  = glb_pkg::MAX_LINE_ITEMS;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECIDE  = 9'b000000010,
    S_SCAN_RD = 9'b000000100,
    S_SCAN_EV = 9'b000001000,
    S_RB_RD   = 9'b000010000,
    S_RB_EV   = 9'b000100000,
    S_CAP     = 9'b001000000,
    S_APPEND  = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [19:0]        iw_r, iasc_r;
  logic signed [20:0] idesc_r;
  logic               ibb_r, iba_r, ifrc_r, ilast_r;
  logic [15:0]        seq_r, item_seq_r, item_seq_nxt;
  logic [15:0]        open_first_r, open_first_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt, k_r, k_nxt, i_r, i_nxt, emit_cnt_r, emit_cnt_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  glb_pkg::bounds_t   bnd_r, bnd_nxt;
  logic               nbb_r, nbb_nxt, split_r, split_nxt;
  logic               emit_cap_r, emit_cap_nxt, emit_last_r, emit_last_nxt;
  logic               emit_frc_r, emit_frc_nxt;
  logic [19:0]        avail_r;
  logic               nowrap_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  glb_pkg::entry_t    ram_wdata, rd;
  logic               accept, out_free, nbb, ovf;
  logic [CW-1:0]      inc, km1;
  logic signed [21:0] hf;
  logic [31:0]        ec32;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign nbb      = (k_r == cnt_r) ? ibb_r : nbb_r;
  assign inc      = i_r + CW'(1);
  assign km1      = k_r - CW'(1);
  assign hf       = $signed({2'b00, iasc_r}) + 22'(idesc_r);
  assign ec32     = 32'(emit_cnt_r);
  assign ovf      = !nowrap_r && (cnt_r != '0) &&
                    (({1'b0, bnd_r.width} + {7'd0, iw_r}) > {7'd0, avail_r});

  assign ram_wdata = '{w: iw_r, asc: iasc_r, desc: idesc_r, bb: ibb_r, ba: iba_r};
  assign ram_waddr = glb_pkg::slot_index(base_r, cnt_r);
  assign ram_we    = (state_r == S_APPEND);
  assign ram_raddr = glb_pkg::slot_index(base_r, (state_r == S_SCAN_RD) ? km1 : i_r);

  glb_ram #(.WIDTH($bits(glb_pkg::entry_t)), .DEPTH(N)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    item_seq_nxt   = item_seq_r;
    open_first_nxt = open_first_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    base_nxt       = base_r;
    bnd_nxt        = bnd_r;
    nbb_nxt        = nbb_r;
    split_nxt      = split_r;
    emit_cnt_nxt   = emit_cnt_r;
    emit_cap_nxt   = emit_cap_r;
    emit_last_nxt  = emit_last_r;
    emit_frc_nxt   = emit_frc_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_seq_nxt = item_seq_r + 16'd1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        emit_cap_nxt = 1'b0;
        emit_frc_nxt = 1'b0;
        if (ifrc_r) begin
          emit_frc_nxt  = (cnt_r == '0);
          emit_cnt_nxt  = cnt_r;
          emit_last_nxt = 1'b1;
          ret_nxt       = S_IDLE;
          state_nxt     = S_EMIT;
        end else if (ovf) begin
          k_nxt     = cnt_r;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_CAP;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        emit_cnt_nxt  = cnt_r;
        emit_last_nxt = !ilast_r;
        ret_nxt       = S_CAP;
        if (rd.ba || nbb) begin
          if (k_r == cnt_r) begin
            state_nxt = S_EMIT;
          end else begin
            bnd_nxt   = '0;
            i_nxt     = '0;
            split_nxt = 1'b1;
            state_nxt = S_RB_RD;
          end
        end else begin
          k_nxt   = km1;
          nbb_nxt = rd.bb;
          state_nxt = (km1 == '0) ? S_EMIT : S_SCAN_RD;
        end
      end
      S_RB_RD: state_nxt = S_RB_EV;
      S_RB_EV: begin
        bnd_nxt = glb_pkg::add_bounds(bnd_r, rd.w, rd.asc, rd.desc);
        i_nxt   = inc;
        if (split_r && inc == k_r) begin
          split_nxt     = 1'b0;
          emit_cnt_nxt  = k_r;
          emit_last_nxt = !ilast_r;
          ret_nxt       = S_RB_RD;
          state_nxt     = S_EMIT;
        end else if (inc == cnt_r) begin
          state_nxt = S_CAP;
        end else begin
          state_nxt = S_RB_RD;
        end
      end
      S_CAP: begin
        if (cnt_r >= CW'(N)) begin
          emit_cnt_nxt  = cnt_r;
          emit_cap_nxt  = 1'b1;
          emit_last_nxt = !ilast_r;
          ret_nxt       = S_APPEND;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        if (cnt_r == '0) open_first_nxt = seq_r;
        cnt_nxt      = cnt_r + CW'(1);
        bnd_nxt      = glb_pkg::add_bounds(bnd_r, iw_r, iasc_r, idesc_r);
        emit_cap_nxt = 1'b0;
        if (ilast_r) begin
          emit_cnt_nxt  = cnt_r + CW'(1);
          emit_last_nxt = 1'b1;
          ret_nxt       = S_IDLE;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          bnd_nxt        = '0;
          cnt_nxt        = cnt_r - emit_cnt_r;
          i_nxt          = i_r - emit_cnt_r;
          open_first_nxt = open_first_r + 16'(emit_cnt_r);
          base_nxt       = glb_pkg::slot_index(base_r, emit_cnt_r);
          emit_cap_nxt   = 1'b0;
          state_nxt      = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      item_seq_r   <= '0;
      open_first_r <= '0;
      cnt_r        <= '0;
      base_r       <= '0;
      bnd_r        <= '0;
      split_r      <= 1'b0;
      out_valid    <= 1'b0;
      avail_r      <= '0;
      nowrap_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      item_seq_r   <= item_seq_nxt;
      open_first_r <= open_first_nxt;
      cnt_r        <= cnt_nxt;
      base_r       <= base_nxt;
      bnd_r        <= bnd_nxt;
      split_r      <= split_nxt;
      if (state_r == S_EMIT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == 1'b0) avail_r <= cfg_wdata;
        else nowrap_r <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    i_r         <= i_nxt;
    nbb_r       <= nbb_nxt;
    emit_cnt_r  <= emit_cnt_nxt;
    emit_cap_r  <= emit_cap_nxt;
    emit_last_r <= emit_last_nxt;
    emit_frc_r  <= emit_frc_nxt;
    if (accept) begin
      iw_r    <= in_item_width;
      iasc_r  <= in_item_ascent;
      idesc_r <= in_item_descent;
      ibb_r   <= in_break_before;
      iba_r   <= in_break_after;
      ifrc_r  <= in_force_break;
      ilast_r <= in_end_of_items;
      seq_r   <= item_seq_r;
    end
    if (state_r == S_EMIT && out_free) begin
      out_capacity_close <= emit_cap_r;
      out_last_line      <= emit_last_r;
      if (emit_frc_r) begin
        out_first_item    <= seq_r;
        out_item_count    <= '0;
        out_line_width    <= '0;
        out_line_height   <= hf[21] ? 21'd0 : hf[20:0];
        out_line_baseline <= iasc_r;
        out_line_descent  <= '0;
      end else begin
        out_first_item    <= open_first_r;
        out_item_count    <= ec32[6:0];
        out_line_width    <= bnd_r.width;
        out_line_height   <= bnd_r.height;
        out_line_baseline <= bnd_r.ascent;
        out_line_descent  <= bnd_r.descent;
      end
    end
  end

  `ASSERT_CLK(a_cnt_bound, cnt_r <= CW'(N), "open line holds more items than the store")
  `ASSERT_CLK(a_rb_index, !(state_r == S_RB_RD) || (i_r < cnt_r), "rebuild index past line end")
  `ASSERT_NEXT(a_emit_load, state_r == S_EMIT && out_free, out_valid, "emit did not load output")
  `ASSERT_NEXT(a_accept_decide, accept, state_r == S_DECIDE, "accepted beat not decoded")

endmodule
